// ===== rtl/core/cfse_pkg.sv =====
// Shared constants of the conflict-free subset enumerator.
`default_nettype none
package cfse_pkg;

  localparam int OP_W      = 2;
  localparam int ROW_IDX_W = 5;
  localparam int ROW_W     = 32;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Item operations
  localparam logic [OP_W-1:0] OP_WRITE_ROW = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART   = 2'd1;
  localparam logic [OP_W-1:0] OP_FETCH     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 2'd1;

endpackage
`default_nettype wire

// ===== rtl/core/cfse_req_if.sv =====
// Request channel: operation, row index and conflict row bits.
`default_nettype none
interface cfse_req_if;
  logic                            valid;
  logic                            ready;
  logic [cfse_pkg::OP_W-1:0]       op;
  logic [cfse_pkg::ROW_IDX_W-1:0]  row_index;
  logic [cfse_pkg::ROW_W-1:0]      row_bits;

  modport source(output valid, output op, output row_index, output row_bits, input ready);
  modport sink(input valid, input op, input row_index, input row_bits, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cfse_rsp_if.sv =====
// Result channel: emitted set mask with found and done flags.
`default_nettype none
interface cfse_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cfse_pkg::ROW_W-1:0]  set_mask;
  logic                        found;
  logic                        done_res;

  modport source(output valid, output set_mask, output found, output done_res, input ready);
  modport sink(input valid, input set_mask, input found, input done_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cfse_cfg_if.sv =====
// Configuration write channel: register index and data.
`default_nettype none
interface cfse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfse_pkg::CFG_IDX_W-1:0]  index;
  logic [cfse_pkg::CNT_W-1:0]      data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/conflict_free_subset_enumerator.sv =====
// Top level: conflict matrix store and backtracking subset search.
`default_nettype none
// Enumerates, one per fetch item, the subsets of exactly set_size items below
// node_count in which no pair conflicts, in lexicographic order of their
// ascending index lists; a fetch after the last set answers done_res. A pair
// conflicts if either row marks the other; the diagonal is ignored. The
// matrix lives in two synchronous memories: the rows as written and a
// transposed copy, so one read of each at the candidate gives every conflict
// of that candidate against the chosen mask. Chosen indices sit on a stack
// memory. Per item: after the accept, a row write sweeps the transposed copy
// one column per cycle over min(MAX_NODES, 32) columns (read-modify-write)
// and holds the request side during the sweep; restart and no-op need nothing
// beyond the accept; a fetch then passes through a check state before each run
// of candidates, tries candidates one per cycle (memory read pipelined against
// the check), backtracks through a stack read and the pop state, and emits
// from the check state, with a pop of the emitted top after it when the set
// is not empty. The length of a fetch is therefore data dependent, and its
// emit waits while the output register still holds an unread result.
// After reset the matrix reads as all clear through per-row valid bits; no
// clearing pass is needed. A result waits in an output register; the
// request side is taken only when the previous item's work is finished.
// Register writes are taken only while the block is idle.
module conflict_free_subset_enumerator #(
  parameter int MAX_NODES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cfse_req_if.sink   req,
  cfse_rsp_if.source rsp,
  cfse_cfg_if.sink   cfg
);
  import cfse_pkg::*;

  // Rows held: row_index is 5 bits, so never more than 32.
  localparam int NROWS = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int AW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int CW    = $clog2(NROWS + 1);
  localparam int SW    = 5;

  typedef enum logic [2:0] {S_IDLE, S_COLS, S_CHECK, S_TEST, S_POP} state_t;
  typedef enum logic [1:0] {K_EMIT, K_PUSH, K_END, K_POP} kind_t;

  // Configuration
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] set_size;

  // Search state
  state_t           state;
  logic [CNT_W-1:0] depth;
  logic [CW-1:0]    cand;
  logic [ROW_W-1:0] chosen;
  logic             exhausted;
  logic             pop_to_idle;

  // Column sweep
  logic [AW-1:0]        sw;
  logic [ROW_IDX_W-1:0] wr_row;
  logic [ROW_W-1:0]     wr_bits;
  logic                 col_pend;
  logic [AW-1:0]        col_waddr;

  // Memories and their valid bits
  logic [ROW_W-1:0] rows_mem [NROWS];
  logic [ROW_W-1:0] cols_mem [NROWS];
  logic [SW-1:0]    stack_mem [32];
  logic [NROWS-1:0] row_valid;
  logic [NROWS-1:0] col_valid;
  logic [ROW_W-1:0] rows_q;
  logic [ROW_W-1:0] cols_q;
  logic             rows_vq;
  logic             cols_vq;
  logic [SW-1:0]    stack_q;

  // Output register
  logic             out_valid;
  logic [ROW_W-1:0] out_mask;
  logic             out_found;
  logic             out_done;

  // Combinational
  logic             in_acc;
  logic             out_free;
  logic             row_ok;
  logic [CW-1:0]    n_act;
  kind_t            kind_chk;
  kind_t            kind_test;
  logic             clash;
  logic [ROW_W-1:0] cand_bit;
  logic [CNT_W-1:0] d_nx;
  logic [CW-1:0]    c_nx;
  logic [ROW_W-1:0] chosen_nx;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic             st_we;
  logic             st_re;
  logic [ROW_W-1:0] col_base;
  logic [ROW_W-1:0] col_wdata;

  function automatic kind_t classify(input logic [CNT_W-1:0] dd, input logic [CW-1:0] cc,
                                     input logic [CW-1:0] nn, input logic [CNT_W-1:0] kk);
    logic [6:0] d7;
    logic [6:0] c7;
    logic [6:0] n7;
    logic [6:0] k7;
    kind_t      res;
    d7 = 7'(dd);
    c7 = 7'(cc);
    n7 = 7'(nn);
    k7 = 7'(kk);
    if (d7 == k7) begin
      res = K_EMIT;
    end else if (d7 < k7 && c7 < n7 && (d7 + (n7 - c7)) >= k7) begin
      res = K_PUSH;
    end else if (d7 == 7'd0) begin
      res = K_END;
    end else begin
      res = K_POP;
    end
    return res;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid    = out_valid;
  assign rsp.set_mask = out_mask;
  assign rsp.found    = out_found;
  assign rsp.done_res = out_done;

  assign row_ok = (7'(req.row_index) < 7'(NROWS));
  assign n_act  = (7'(node_count) > 7'(NROWS)) ? CW'(NROWS) : CW'(node_count);

  // One candidate step: clash test against everything chosen so far
  assign cand_bit  = ROW_W'(1) << cand;
  assign clash     = |(((rows_vq ? rows_q : '0) | (cols_vq ? cols_q : '0))
                       & chosen & ~cand_bit);
  assign d_nx      = clash ? depth : depth + CNT_W'(1);
  assign chosen_nx = clash ? chosen : (chosen | cand_bit);
  assign c_nx      = cand + CW'(1);
  assign kind_chk  = classify(depth, cand, n_act, set_size);
  assign kind_test = classify(d_nx, c_nx, n_act, set_size);

  assign st_we = (state == S_TEST) && !clash;
  assign st_re = (state == S_CHECK) && !exhausted &&
                 (kind_chk == K_POP ||
                  (kind_chk == K_EMIT && out_free && depth != '0));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cand[AW-1:0];
    case (state)
      S_COLS: begin
        mem_re    = 1'b1;
        mem_raddr = sw;
      end
      S_CHECK: begin
        mem_re    = !exhausted && (kind_chk == K_PUSH);
        mem_raddr = cand[AW-1:0];
      end
      S_TEST: begin
        mem_re    = (kind_test == K_PUSH);
        mem_raddr = c_nx[AW-1:0];
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = cand[AW-1:0];
      end
    endcase
  end

  // Transposed copy: column c gets bit wr_row set to the written row's bit c
  always_comb begin
    col_base          = cols_vq ? cols_q : '0;
    col_wdata         = col_base;
    col_wdata[wr_row] = wr_bits[col_waddr];
  end

  // Matrix memories
  always_ff @(posedge clk) begin
    if (in_acc && req.op == OP_WRITE_ROW && row_ok) begin
      rows_mem[req.row_index[AW-1:0]] <= req.row_bits;
    end
    if (col_pend) begin
      cols_mem[col_waddr] <= col_wdata;
    end
    if (mem_re) begin
      rows_q  <= rows_mem[mem_raddr];
      cols_q  <= cols_mem[mem_raddr];
      rows_vq <= row_valid[mem_raddr];
      cols_vq <= col_valid[mem_raddr];
    end
  end

  // Choice stack
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[depth[SW-1:0]] <= SW'(cand);
    end
    if (st_re) begin
      stack_q <= stack_mem[SW'(depth - CNT_W'(1))];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      col_valid <= '0;
    end else begin
      if (in_acc && req.op == OP_WRITE_ROW && row_ok) begin
        row_valid[req.row_index[AW-1:0]] <= 1'b1;
      end
      if (col_pend) begin
        col_valid[col_waddr] <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      set_size   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_NODE_COUNT: node_count <= cfg.data;
        REG_SET_SIZE:   set_size   <= cfg.data;
        default:        ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth       <= '0;
      cand        <= '0;
      chosen      <= '0;
      exhausted   <= 1'b0;
      pop_to_idle <= 1'b0;
      sw          <= '0;
      col_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      col_pend <= 1'b0;
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req.op)
              OP_WRITE_ROW: begin
                if (row_ok) begin
                  state   <= S_COLS;
                  sw      <= '0;
                  wr_row  <= req.row_index;
                  wr_bits <= req.row_bits;
                end
              end
              OP_RESTART: begin
                depth     <= '0;
                cand      <= '0;
                chosen    <= '0;
                exhausted <= 1'b0;
              end
              OP_FETCH: state <= S_CHECK;
              default:  ;
            endcase
          end
        end
        S_COLS: begin
          col_pend  <= 1'b1;
          col_waddr <= sw;
          sw        <= sw + AW'(1);
          if (sw == AW'(NROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (exhausted) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_mask  <= '0;
              out_found <= 1'b0;
              out_done  <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            case (kind_chk)
              K_EMIT: begin
                if (out_free) begin
                  out_valid <= 1'b1;
                  out_mask  <= chosen;
                  out_found <= 1'b1;
                  out_done  <= 1'b0;
                  if (depth == '0) begin
                    exhausted <= 1'b1;
                    state     <= S_IDLE;
                  end else begin
                    pop_to_idle <= 1'b1;
                    state       <= S_POP;
                  end
                end
              end
              K_PUSH: state <= S_TEST;
              K_END:  exhausted <= 1'b1;
              K_POP: begin
                pop_to_idle <= 1'b0;
                state       <= S_POP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TEST: begin
          chosen <= chosen_nx;
          depth  <= d_nx;
          cand   <= c_nx;
          state  <= (kind_test == K_PUSH) ? S_TEST : S_CHECK;
        end
        S_POP: begin
          chosen <= chosen & ~(ROW_W'(1) << stack_q);
          cand   <= CW'(stack_q) + CW'(1);
          depth  <= depth - CNT_W'(1);
          state  <= pop_to_idle ? S_IDLE : S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is either a set or the end mark, never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.found ^ rsp.done_res))
    else $error("result carries both or neither of found and done_res");

  // Stack depth tracks the chosen mask
  a_depth_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(chosen) == int'(depth))
    else $error("chosen mask disagrees with stack depth");

  // Stack holds ascending indices, all below the candidate
  a_depth_cand: assert property (@(posedge clk) disable iff (rst)
    7'(depth) <= 7'(cand))
    else $error("stack depth beyond candidate index");

  // A fetch keeps the request side closed while it searches
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == OP_FETCH) |=> !req.ready)
    else $error("request taken during a fetch");

endmodule
`default_nettype wire

// ===== dv/tb_conflict_free_subset_enumerator.sv =====
// Testbench for the conflict-free subset enumerator: random traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_conflict_free_subset_enumerator;
  import cfse_pkg::*;

  // Matrix size of the instance; the predictor clamps node_count to it.
  localparam int NODE_LIMIT = 32;
  // The only op code the package leaves unnamed: the block ignores it.
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

  // Random items to send after the directed part (ignored op codes not counted).
  localparam int RANDOM_ITEMS  = 1250;
  // A row write sweeps MAX_NODES columns and gives no result, so the block may
  // still be busy after the last expected result; wait this long before any
  // register write and at the end.
  localparam int SETTLE_CYCLES = 64;
  // Long receiver hold-off: length, first trigger point and spacing in items.
  localparam int HOLD_CYCLES   = 1500;
  localparam int HOLD_FIRST    = 300;
  localparam int HOLD_SPACING  = 500;
  // Slowest legal run: every item a row write plus worst sender gap and receiver
  // stall, the hold-offs, and one full search tree per restart.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_bits;
  } req_item_t;

  typedef struct {
    logic [ROW_W-1:0] set_mask;
    logic             found;
    logic             done_res;
  } set_result_t;

  logic clk;
  logic rst;

  cfse_req_if req_ch();
  cfse_rsp_if rsp_ch();
  cfse_cfg_if cfg_ch();

  conflict_free_subset_enumerator #(
    .MAX_NODES(NODE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: matrix, choice stack and search position, plus its own
  // copy of the two registers.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]     conflict_row_copy [NODE_LIMIT];
  logic [ROW_IDX_W-1:0] pick_stack [32];
  int                   pick_depth;
  int                   pick_next;
  logic [ROW_W-1:0]     picked_mask;
  bit                   search_over;
  logic [CNT_W-1:0]     node_count_q;
  logic [CNT_W-1:0]     set_size_q;

  req_item_t   pending_items [$];
  set_result_t expected_sets [$];

  int          items_queued;
  int          items_accepted;
  int          random_queued;
  int          mismatch_count;
  int unsigned cycle_count = 0;

  // Sender burst shaping and receiver stall pattern
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        stall_left;
  req_item_t next_req;

  // Long hold-off of the receiver
  logic hold_active;
  int   hold_count;
  int   hold_trigger;

  function automatic void restart_search();
    pick_depth  = 0;
    pick_next   = 0;
    picked_mask = '0;
    search_over = 1'b0;
  endfunction

  // A candidate is blocked if any chosen item conflicts with it in either
  // direction; the diagonal bit never counts.
  function automatic bit candidate_blocked(int cand);
    if (cand >= NODE_LIMIT || cand >= 32) return 1'b1;
    if ((conflict_row_copy[cand] & picked_mask & ~(32'd1 << cand)) != '0) return 1'b1;
    for (int j = 0; j < NODE_LIMIT && j < 32; j++) begin
      if (j != cand && picked_mask[j] && conflict_row_copy[j][cand]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drop the top choice and carry on just past it.
  function automatic void pop_pick();
    int top;
    pick_depth--;
    top = pick_stack[pick_depth & 31];
    picked_mask[top] = 1'b0;
    pick_next = top + 1;
  endfunction

  // Depth-first walk to the next conflict-free set of set_size items, in
  // lexicographic order; resumes from the stack as it stands.
  function automatic set_result_t next_subset();
    int          active;
    set_result_t res;
    active = node_count_q;
    if (active > NODE_LIMIT) active = NODE_LIMIT;
    if (active > 32) active = 32;
    while (!search_over) begin
      if (pick_depth == set_size_q) begin
        res.set_mask = picked_mask;
        res.found    = 1'b1;
        res.done_res = 1'b0;
        // the empty set is given once only
        if (pick_depth == 0) search_over = 1'b1;
        else pop_pick();
        return res;
      end
      if (pick_depth < set_size_q && pick_next < active &&
          pick_depth + (active - pick_next) >= set_size_q) begin
        if (!candidate_blocked(pick_next) && pick_depth < 32) begin
          pick_stack[pick_depth & 31] = pick_next[ROW_IDX_W-1:0];
          picked_mask[pick_next]      = 1'b1;
          pick_depth++;
        end
        pick_next++;
      end else if (pick_depth == 0) begin
        search_over = 1'b1;
      end else begin
        pop_pick();
      end
    end
    res.set_mask = '0;
    res.found    = 1'b0;
    res.done_res = 1'b1;
    return res;
  endfunction

  function automatic void predict_item(req_item_t it);
    case (it.op)
      OP_WRITE_ROW: begin
        if (it.row_index < NODE_LIMIT) conflict_row_copy[it.row_index] = it.row_bits;
      end
      OP_RESTART: restart_search();
      OP_FETCH:   expected_sets.push_back(next_subset());
      default: ;
    endcase
  endfunction

  // Mostly sparse rows so that sets exist, with empty, full and one-hot rows mixed in.
  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3, 4:    return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [ROW_IDX_W-1:0] idx,
                            input logic [ROW_W-1:0] bits);
    req_item_t it;
    it.op        = op;
    it.row_index = idx;
    it.row_bits  = bits;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_counted(input logic [OP_W-1:0] op);
    queue_item(op, ROW_IDX_W'($urandom_range(0, 31)),
               op == OP_WRITE_ROW ? random_row() : $urandom);
    if (op != OP_IDLE) random_queued++;
  endtask

  // Called at a clock edge; after the write, valid is dropped and the task waits
  // with valid low so that back to back writes never assign valid twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_NODE_COUNT: node_count_q = val;
      REG_SET_SIZE:   set_size_q   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every item is taken, every result is back and the block is idle.
  task automatic drain_and_settle();
    while (items_accepted != items_queued) @(posedge clk);
    while (expected_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: a few row writes, usually a restart, then mainly
  // fetches so that enumerations run deep, with noise mixed in.
  task automatic queue_random_phase();
    int sel;
    repeat ($urandom_range(0, 6)) queue_counted(OP_WRITE_ROW);
    if ($urandom_range(0, 9) != 0) queue_counted(OP_RESTART);
    repeat ($urandom_range(4, 40)) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) queue_counted(OP_IDLE);
      else if (sel == 1) queue_counted(OP_WRITE_ROW);
      else if (sel == 2) queue_counted(OP_RESTART);
      else queue_counted(OP_FETCH);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed phases, then random phases with register changes only
  // while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] nodes;
    logic [CNT_W-1:0] size;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_IDLE;
    req_ch.row_index = '0;
    req_ch.row_bits  = '0;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_NODE_COUNT;
    cfg_ch.data      = '0;
    items_queued     = 0;
    random_queued    = 0;
    mismatch_count   = 0;
    for (int i = 0; i < NODE_LIMIT; i++) conflict_row_copy[i] = '0;
    for (int i = 0; i < 32; i++) pick_stack[i] = '0;
    node_count_q = '0;
    set_size_q   = '0;
    restart_search();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: set size 0 gives one empty set, then done; an idle op
    // changes nothing and a restart gives the empty set again.
    queue_item(OP_FETCH, '0, '0);
    queue_item(OP_FETCH, '1, '1);
    queue_item(OP_IDLE, 5'd31, '1);
    queue_item(OP_RESTART, '0, '0);
    queue_item(OP_FETCH, '0, '0);
    drain_and_settle();

    // Four items, pairs: item 0 clashes with all (its own bit too), item 3
    // marks only itself, which must not count. Expect {1,2} {1,3} {2,3} done.
    write_reg(REG_NODE_COUNT, 6'd4);
    write_reg(REG_SET_SIZE, 6'd2);
    queue_item(OP_WRITE_ROW, 5'd0, '1);
    queue_item(OP_WRITE_ROW, 5'd3, 32'h0000_0008);
    queue_item(OP_WRITE_ROW, 5'd31, 32'h8000_0001);
    queue_item(OP_RESTART, '0, '0);
    repeat (5) queue_item(OP_FETCH, '0, '0);
    drain_and_settle();

    // Set size beyond the item count: first fetch says done.
    write_reg(REG_NODE_COUNT, 6'd32);
    write_reg(REG_SET_SIZE, 6'd33);
    queue_item(OP_RESTART, '0, '0);
    queue_item(OP_FETCH, '0, '0);
    queue_item(OP_FETCH, '0, '0);

    while (random_queued < RANDOM_ITEMS) begin
      drain_and_settle();
      if ($urandom_range(0, 4) == 0) begin
        // extremes; sizes kept to those whose search tree stays small
        case ($urandom_range(0, 7))
          0:       begin nodes = 6'd32; size = 6'd0;  end
          1:       begin nodes = 6'd32; size = 6'd1;  end
          2:       begin nodes = 6'd32; size = 6'd2;  end
          3:       begin nodes = 6'd32; size = 6'd31; end
          4:       begin nodes = 6'd32; size = 6'd32; end
          5:       begin nodes = 6'd63; size = 6'd2;  end
          6:       begin nodes = 6'd32; size = 6'd63; end
          default: begin nodes = 6'd0;  size = CNT_W'($urandom_range(0, 1)); end
        endcase
      end else begin
        nodes = CNT_W'($urandom_range(0, 10));
        size  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 63))
                                             : CNT_W'($urandom_range(0, nodes + 1));
      end
      // now and then one register is left as it was
      if ($urandom_range(0, 7) != 0) write_reg(REG_NODE_COUNT, nodes);
      if ($urandom_range(0, 7) != 0) write_reg(REG_SET_SIZE, size);
      queue_random_phase();
    end

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps. The predictor
  // runs on each item as the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      items_accepted <= 0;
      burst_left     = 1;
      gap_left       = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_req.op        = req_ch.op;
        next_req.row_index = req_ch.row_index;
        next_req.row_bits  = req_ch.row_bits;
        predict_item(next_req);
        items_accepted <= items_accepted + 1;
      end
      // a held item stays put until taken
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          req_ch.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          next_req = pending_items.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.op        <= next_req.op;
          req_ch.row_index <= next_req.row_index;
          req_ch.row_bits  <= next_req.row_bits;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a third of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Long hold-off: the receiver stops for HOLD_CYCLES while the sender keeps
  // offering, so the output register fills and the request side stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_active  <= 1'b0;
      hold_count   <= 0;
      hold_trigger <= HOLD_FIRST;
    end else if (hold_active) begin
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_active  <= 1'b0;
        hold_trigger <= hold_trigger + HOLD_SPACING;
      end
      hold_count <= hold_count + 1;
    end else if (items_accepted >= hold_trigger) begin
      hold_active <= 1'b1;
      hold_count  <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: receiver stall pattern switches between always ready,
  // coin toss and mostly stalled; each result is checked against the oldest
  // expected set.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode   = 0;
      stall_left   = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_sets.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result mask=%h found=%b done=%b", $realtime,
                     rsp_ch.set_mask, rsp_ch.found, rsp_ch.done_res);
        end else begin
          if (rsp_ch.set_mask !== expected_sets[0].set_mask ||
              rsp_ch.found !== expected_sets[0].found ||
              rsp_ch.done_res !== expected_sets[0].done_res) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp mask=%h found=%b done=%b, got mask=%h found=%b done=%b",
                       $realtime, expected_sets[0].set_mask, expected_sets[0].found,
                       expected_sets[0].done_res, rsp_ch.set_mask, rsp_ch.found,
                       rsp_ch.done_res);
          end
          void'(expected_sets.pop_front());
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(32, 256);
      end else begin
        stall_left--;
      end
      rsp_ch.ready <= !hold_active &&
                      (stall_mode == 0 ||
                       (stall_mode == 1 && $urandom_range(0, 1) == 1) ||
                       (stall_mode == 2 && $urandom_range(0, 4) == 0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
